// ----- rtl/uniform_grid_spatial_index_defines.svh -----
// assertion macros for the uniform grid spatial index
// used by the port checker; relies on i_clk and i_rst_n being in scope
`ifndef UNIFORM_GRID_SPATIAL_INDEX_DEFINES_SVH
`define UNIFORM_GRID_SPATIAL_INDEX_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UGSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define UGSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ugsi_pkg.sv -----
// shared constants, types and helpers of the uniform grid spatial index
// no dependencies
package ugsi_pkg;

    localparam int MAX_ENTITIES  = 64;
    localparam int MAX_GRID_SIDE = 16;
    localparam int NCELLS        = MAX_GRID_SIDE * MAX_GRID_SIDE;
    localparam int SLOT_W        = $clog2(MAX_ENTITIES);
    localparam int CNT_W         = $clog2(MAX_ENTITIES + 1);
    localparam int SIDE_W        = $clog2(MAX_GRID_SIDE + 1);
    localparam int COORD_W       = $clog2(MAX_GRID_SIDE);
    localparam int CELL_W        = $clog2(NCELLS);
    localparam int KEY_W         = 32;
    localparam int DVD_W         = 33;
    localparam int DVS_W         = 16;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_MOVE   = 3'd2;
    localparam logic [2:0] REQ_QUERY  = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] CFG_WORLD_W   = 2'd0;
    localparam logic [1:0] CFG_WORLD_H   = 2'd1;
    localparam logic [1:0] CFG_CELL_SIZE = 2'd2;

    typedef struct packed {
        logic [15:0] extent_x;
        logic [15:0] extent_y;
        logic [15:0] cell_len;
    } t_geom;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] id;
        logic             hit;
        logic             last;
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } t_emit;

    // grid side from a ceiling quotient, kept in 1..MAX_GRID_SIDE
    function automatic logic [SIDE_W-1:0] f_side(input logic [DVD_W-1:0] q);
        logic [SIDE_W-1:0] s;
        if (q == '0) begin
            s = SIDE_W'(1);
        end else if (q > DVD_W'(MAX_GRID_SIDE)) begin
            s = SIDE_W'(MAX_GRID_SIDE);
        end else begin
            s = q[SIDE_W-1:0];
        end
        return s;
    endfunction

    // column or row from a quotient, clamped to the last one of the side
    function automatic logic [COORD_W-1:0] f_coord(input logic [DVD_W-1:0] q,
                                                   input logic [SIDE_W-1:0] side);
        logic [COORD_W-1:0] c;
        if (q >= DVD_W'(side)) begin
            c = COORD_W'(side - SIDE_W'(1));
        end else begin
            c = q[COORD_W-1:0];
        end
        return c;
    endfunction

endpackage

// ----- rtl/ugsi_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on ugsi_pkg
module ugsi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ugsi_pkg::DVD_W-1:0]  i_dividend,
    input  logic [ugsi_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [ugsi_pkg::DVD_W-1:0]  o_quot
);
    import ugsi_pkg::*;

    localparam int CNT_BITS = $clog2(DVD_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DVD_W-1:0]    r_q;
    logic [DVS_W-1:0]    r_rem;
    logic [DVS_W-1:0]    r_dvs;
    logic [DVS_W:0]      sh;
    logic [DVS_W:0]      diff;
    logic                fits;

    assign sh   = {r_rem, r_q[DVD_W-1]};
    assign diff = sh - {1'b0, r_dvs};
    assign fits = (sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DVD_W - 1);
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[DVD_W-2:0], fits};
                r_rem <= fits ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_BITS'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/ugsi_ctrl.sv -----
// request sequencer of the spatial index: geometry, slot scan, cell lists, query walk
// depends on ugsi_pkg; drives the shared divider
module ugsi_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_req_type,
    input  logic [31:0]                 i_entity_id,
    input  logic signed [31:0]          i_pos_x,
    input  logic signed [31:0]          i_pos_y,
    input  logic signed [31:0]          i_radius,
    input  ugsi_pkg::t_geom             i_geom,
    output logic                        o_div_start,
    output logic [ugsi_pkg::DVD_W-1:0]  o_div_dividend,
    output logic [ugsi_pkg::DVS_W-1:0]  o_div_divisor,
    input  logic                        i_div_done,
    input  logic [ugsi_pkg::DVD_W-1:0]  i_div_quot,
    output ugsi_pkg::t_emit             o_emit,
    input  logic                        i_emit_ok
);
    import ugsi_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE      = 23'h000001,
        S_DIV_GO    = 23'h000002,
        S_DIV_WAIT  = 23'h000004,
        S_SCAN_RD   = 23'h000008,
        S_SCAN_CMP  = 23'h000010,
        S_DISP      = 23'h000020,
        S_CELL_WAIT = 23'h000040,
        S_U_FRD     = 23'h000080,
        S_U_FCHK    = 23'h000100,
        S_U_MRD     = 23'h000200,
        S_U_MCMP    = 23'h000400,
        S_U_MOVE    = 23'h000800,
        S_U_DONE    = 23'h001000,
        S_L_FRD     = 23'h002000,
        S_L_WR      = 23'h004000,
        S_Q_CELL    = 23'h008000,
        S_Q_FILL    = 23'h010000,
        S_Q_MRD     = 23'h020000,
        S_Q_KRD     = 23'h040000,
        S_Q_EMIT    = 23'h080000,
        S_Q_NEXT    = 23'h100000,
        S_Q_FLUSH   = 23'h200000,
        S_EMIT      = 23'h400000
    } t_state;

    localparam logic [2:0] PH_COLS = 3'd0;
    localparam logic [2:0] PH_ROWS = 3'd1;
    localparam logic [2:0] PH_X0   = 3'd2;
    localparam logic [2:0] PH_X1   = 3'd3;
    localparam logic [2:0] PH_Y0   = 3'd4;
    localparam logic [2:0] PH_Y1   = 3'd5;

    localparam int MEM_AW = CELL_W + SLOT_W;

    t_state r_state;

    // latched request
    logic [2:0]         r_req;
    logic [KEY_W-1:0]   r_key;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_rad;
    logic [1:0]         r_st;

    // geometry
    logic [2:0]         r_ph;
    logic [SIDE_W-1:0]  r_cols;
    logic [SIDE_W-1:0]  r_rows;
    logic [COORD_W-1:0] r_x0, r_x1, r_y0, r_y1;
    logic [COORD_W-1:0] r_cx, r_cy;

    // slot scan and list walk
    logic [CNT_W-1:0]   r_idx;
    logic               r_found;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_free_v;
    logic [SLOT_W-1:0]  r_free;
    logic [CELL_W-1:0]  r_ucell;
    logic [CELL_W-1:0]  r_lcell;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_k;
    logic [SLOT_W-1:0]  r_m;
    logic [KEY_W-1:0]   r_pend;
    logic               r_pend_v;
    logic [CNT_W-1:0]   r_total;

    // stores
    logic [MAX_ENTITIES-1:0] r_svalid;
    logic [NCELLS-1:0]       r_cvalid;
    logic [KEY_W-1:0]        m_key  [MAX_ENTITIES];
    logic [CELL_W-1:0]       m_cell [MAX_ENTITIES];
    logic [CNT_W-1:0]        m_fill [NCELLS];
    logic [SLOT_W-1:0]       m_mem  [NCELLS * MAX_ENTITIES];
    logic [KEY_W-1:0]        r_key_q;
    logic [CELL_W-1:0]       r_cell_q;
    logic [CNT_W-1:0]        r_fill_q;
    logic                    r_fvld_q;
    logic [SLOT_W-1:0]       r_mem_q;

    logic [15:0]        cs_eff;
    logic signed [33:0] rad_q;
    logic signed [33:0] dvd;
    logic               is_q;
    logic               ph_last;
    logic [2:0]         ph_next;
    logic               div_store;
    logic [DVD_W-1:0]   div_q;
    logic [8:0]         cell_sum;
    logic [8:0]         qcell_sum;
    logic [CELL_W-1:0]  cell_new;
    logic [CELL_W-1:0]  qcell;
    logic [CNT_W-1:0]   fill_eff;
    logic [CNT_W-1:0]   n_last;
    logic               add_ok;
    logic               link_ok;
    logic               key_we;
    logic               cell_we;
    logic [SLOT_W-1:0]  cell_waddr;
    logic [SLOT_W-1:0]  key_raddr;
    logic [CELL_W-1:0]  fill_raddr;
    logic               fill_we;
    logic [CELL_W-1:0]  fill_waddr;
    logic [CNT_W-1:0]   fill_wdata;
    logic [MEM_AW-1:0]  mem_raddr;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [SLOT_W-1:0]  mem_wdata;

    assign cs_eff = (i_geom.cell_len == '0) ? 16'd1 : i_geom.cell_len;
    assign rad_q  = (r_req == REQ_QUERY) ? 34'(r_rad) : 34'sd0;
    assign is_q   = (r_req == REQ_QUERY);

    always_comb begin
        case (r_ph)
            PH_COLS: dvd = $signed(34'(i_geom.extent_x) + 34'(cs_eff) - 34'd1);
            PH_ROWS: dvd = $signed(34'(i_geom.extent_y) + 34'(cs_eff) - 34'd1);
            PH_X0:   dvd = 34'(r_px) - rad_q;
            PH_X1:   dvd = 34'(r_px) + rad_q;
            PH_Y0:   dvd = 34'(r_py) - rad_q;
            default: dvd = 34'(r_py) + rad_q;
        endcase
    end

    assign o_div_start    = (r_state == S_DIV_GO) && !dvd[33];
    assign o_div_dividend = dvd[DVD_W-1:0];
    assign o_div_divisor  = cs_eff;

    // negative dividends truncate to zero or below, clamped to column or row zero
    assign div_store = ((r_state == S_DIV_GO) && dvd[33]) ||
                       ((r_state == S_DIV_WAIT) && i_div_done);
    assign div_q     = (r_state == S_DIV_WAIT) ? i_div_quot : '0;

    always_comb begin
        if (is_q) begin
            ph_last = (r_ph == PH_Y1);
            ph_next = r_ph + 3'd1;
        end else begin
            ph_last = (r_ph == PH_Y0);
            ph_next = (r_ph == PH_X0) ? PH_Y0 : r_ph + 3'd1;
        end
    end

    assign cell_sum  = 9'(r_y0) * 9'(r_cols) + 9'(r_x0);
    assign qcell_sum = 9'(r_cy) * 9'(r_cols) + 9'(r_cx);
    assign cell_new  = cell_sum[CELL_W-1:0];
    assign qcell     = qcell_sum[CELL_W-1:0];

    assign fill_eff = r_fvld_q ? r_fill_q : '0;
    assign n_last   = r_n - CNT_W'(1);
    assign add_ok   = (r_req == REQ_ADD) && !r_found && r_free_v &&
                      (r_total < CNT_W'(MAX_ENTITIES));
    assign link_ok  = (r_state == S_L_WR) && (fill_eff < CNT_W'(MAX_ENTITIES));

    assign key_we     = (r_state == S_DISP) && add_ok;
    assign cell_we    = key_we || ((r_state == S_U_DONE) && (r_req == REQ_MOVE));
    assign cell_waddr = (r_state == S_DISP) ? r_free : r_slot;

    // read addresses
    always_comb begin
        case (r_state)
            S_SCAN_RD: key_raddr = r_idx[SLOT_W-1:0];
            S_Q_KRD:   key_raddr = r_mem_q;
            default:   key_raddr = r_m;
        endcase
        case (r_state)
            S_U_FRD: fill_raddr = r_ucell;
            S_L_FRD: fill_raddr = r_lcell;
            default: fill_raddr = qcell;
        endcase
        case (r_state)
            S_U_MRD:  mem_raddr = {r_ucell, r_k[SLOT_W-1:0]};
            S_U_MCMP: mem_raddr = {r_ucell, n_last[SLOT_W-1:0]};
            default:  mem_raddr = {qcell, r_k[SLOT_W-1:0]};
        endcase
    end

    // write ports: swap-in on unlink, append on link
    always_comb begin
        fill_we    = 1'b0;
        fill_waddr = r_lcell;
        fill_wdata = fill_eff + CNT_W'(1);
        mem_we     = 1'b0;
        mem_waddr  = {r_lcell, fill_eff[SLOT_W-1:0]};
        mem_wdata  = r_slot;
        if (r_state == S_U_MOVE) begin
            fill_we    = 1'b1;
            fill_waddr = r_ucell;
            fill_wdata = n_last;
            mem_we     = 1'b1;
            mem_waddr  = {r_ucell, r_k[SLOT_W-1:0]};
            mem_wdata  = r_mem_q;
        end else if (link_ok) begin
            fill_we = 1'b1;
            mem_we  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_q <= m_key[key_raddr];
        if (key_we) begin
            m_key[r_free] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell_q <= m_cell[r_slot];
        if (cell_we) begin
            m_cell[cell_waddr] <= cell_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_q <= m_fill[fill_raddr];
        r_fvld_q <= r_cvalid[fill_raddr];
        if (fill_we) begin
            m_fill[fill_waddr] <= fill_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem_q <= m_mem[mem_raddr];
        if (mem_we) begin
            m_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_store) begin
            case (r_ph)
                PH_COLS: r_cols <= f_side(div_q);
                PH_ROWS: r_rows <= f_side(div_q);
                PH_X0:   r_x0   <= f_coord(div_q, r_cols);
                PH_X1:   r_x1   <= f_coord(div_q, r_cols);
                PH_Y0:   r_y0   <= f_coord(div_q, r_rows);
                default: r_y1   <= f_coord(div_q, r_rows);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_svalid <= '0;
            r_cvalid <= '0;
            r_total  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req    <= i_req_type;
                        r_key    <= i_entity_id;
                        r_px     <= i_pos_x;
                        r_py     <= i_pos_y;
                        r_rad    <= i_radius;
                        r_st     <= ST_DONE;
                        r_ph     <= PH_COLS;
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_free_v <= 1'b0;
                        r_pend_v <= 1'b0;
                        case (i_req_type)
                            REQ_ADD, REQ_MOVE: r_state <= S_DIV_GO;
                            REQ_REMOVE:        r_state <= S_SCAN_RD;
                            REQ_QUERY: begin
                                r_state <= i_radius[31] ? S_EMIT : S_DIV_GO;
                            end
                            REQ_CLEAR: begin
                                r_svalid <= '0;
                                r_cvalid <= '0;
                                r_total  <= '0;
                                r_state  <= S_EMIT;
                            end
                            default: begin
                                r_st    <= ST_IGNORED;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_DIV_GO, S_DIV_WAIT: begin
                    if (div_store) begin
                        r_ph <= ph_next;
                        if (!ph_last) begin
                            r_state <= S_DIV_GO;
                        end else if (is_q) begin
                            r_cx    <= r_x0;
                            r_cy    <= r_y0;
                            r_state <= S_Q_CELL;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CMP;
                S_SCAN_CMP: begin
                    if (r_svalid[r_idx[SLOT_W-1:0]] && r_key_q == r_key) begin
                        r_found <= 1'b1;
                        r_slot  <= r_idx[SLOT_W-1:0];
                        r_state <= S_DISP;
                    end else begin
                        if (!r_svalid[r_idx[SLOT_W-1:0]] && !r_free_v) begin
                            r_free_v <= 1'b1;
                            r_free   <= r_idx[SLOT_W-1:0];
                        end
                        if (r_idx == CNT_W'(MAX_ENTITIES - 1)) begin
                            r_state <= S_DISP;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_DISP: begin
                    if (r_req == REQ_ADD) begin
                        if (r_found) begin
                            r_st    <= ST_IGNORED;
                            r_state <= S_EMIT;
                        end else if (!add_ok) begin
                            r_st    <= ST_FULL;
                            r_state <= S_EMIT;
                        end else begin
                            r_svalid[r_free] <= 1'b1;
                            r_total          <= r_total + CNT_W'(1);
                            r_slot           <= r_free;
                            r_lcell          <= cell_new;
                            r_state          <= S_L_FRD;
                        end
                    end else if (!r_found) begin
                        r_st    <= ST_IGNORED;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_CELL_WAIT;
                    end
                end
                S_CELL_WAIT: begin
                    r_ucell <= r_cell_q;
                    if (r_req == REQ_MOVE && r_cell_q == cell_new) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_U_FRD;
                    end
                end
                S_U_FRD: r_state <= S_U_FCHK;
                S_U_FCHK: begin
                    r_n     <= fill_eff;
                    r_k     <= '0;
                    r_state <= (fill_eff == '0) ? S_U_DONE : S_U_MRD;
                end
                S_U_MRD: r_state <= S_U_MCMP;
                S_U_MCMP: begin
                    if (r_mem_q == r_slot) begin
                        r_state <= S_U_MOVE;
                    end else if (r_k + CNT_W'(1) < r_n) begin
                        r_k     <= r_k + CNT_W'(1);
                        r_state <= S_U_MRD;
                    end else begin
                        r_state <= S_U_DONE;
                    end
                end
                S_U_MOVE: r_state <= S_U_DONE;
                S_U_DONE: begin
                    if (r_req == REQ_REMOVE) begin
                        r_svalid[r_slot] <= 1'b0;
                        if (r_total != '0) begin
                            r_total <= r_total - CNT_W'(1);
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_lcell <= cell_new;
                        r_state <= S_L_FRD;
                    end
                end
                S_L_FRD: r_state <= S_L_WR;
                S_L_WR: begin
                    if (link_ok) begin
                        r_cvalid[r_lcell] <= 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_Q_CELL: r_state <= S_Q_FILL;
                S_Q_FILL: begin
                    r_n     <= fill_eff;
                    r_k     <= '0;
                    r_state <= (fill_eff == '0) ? S_Q_NEXT : S_Q_MRD;
                end
                S_Q_MRD: r_state <= S_Q_KRD;
                S_Q_KRD: begin
                    r_m     <= r_mem_q;
                    r_state <= S_Q_EMIT;
                end
                S_Q_EMIT: begin
                    // the previous hit goes out once a newer one shows it was not last
                    if (!r_pend_v || i_emit_ok) begin
                        r_pend   <= r_key_q;
                        r_pend_v <= 1'b1;
                        if (r_k + CNT_W'(1) < r_n) begin
                            r_k     <= r_k + CNT_W'(1);
                            r_state <= S_Q_MRD;
                        end else begin
                            r_state <= S_Q_NEXT;
                        end
                    end
                end
                S_Q_NEXT: begin
                    if (r_cx < r_x1) begin
                        r_cx    <= r_cx + COORD_W'(1);
                        r_state <= S_Q_CELL;
                    end else if (r_cy < r_y1) begin
                        r_cy    <= r_cy + COORD_W'(1);
                        r_cx    <= r_x0;
                        r_state <= S_Q_CELL;
                    end else begin
                        r_state <= S_Q_FLUSH;
                    end
                end
                S_Q_FLUSH, S_EMIT: begin
                    if (i_emit_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_emit.valid  = (r_state == S_EMIT) || (r_state == S_Q_FLUSH) ||
                        ((r_state == S_Q_EMIT) && r_pend_v);
        o_emit.id     = ((r_state == S_EMIT) || !r_pend_v) ? '0 : r_pend;
        o_emit.hit    = (r_state != S_EMIT) && r_pend_v;
        o_emit.last   = (r_state != S_Q_EMIT);
        o_emit.status = (r_state == S_EMIT) ? r_st : ST_DONE;
        o_emit.count  = r_total;
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// ----- rtl/uniform_grid_spatial_index.sv -----
// top level of the uniform grid spatial index: config registers, result register
// depends on ugsi_pkg, ugsi_div and ugsi_ctrl
//
// requests enter on i_in_valid / o_in_stall; a request is taken when valid is high
// and stall is low. one request is worked on at a time; o_in_stall is high until
// its last result has been handed to the result register.
// results leave on o_out_valid / i_out_stall through a single result register;
// while i_out_stall is high the register holds and the sequencer waits.
// add, remove, move, clear and reserved codes give one result with o_last set.
// a query gives one result per member of the cells in its box, o_last on the final
// one, or a single empty result when the radius is negative or nothing is found.
// latency is set by the shared 33-step divider (skipped for a negative dividend)
// and by the slot scan, which reads and compares one slot at a time: add takes
// 4 divisions plus a scan of the slots that stops at a matching id, move 4 divisions
// plus a scan up to its slot and a search of its old cell, remove a scan up to its
// slot plus a search of its cell, clear and reserved codes go straight to a result,
// query 6 divisions, then a walk of every cell in its box and every member found.
// the config port (i_cfg_valid, o_cfg_ready) is always ready; index 3 is ignored.
// reset clears the slot and cell valid bits at once, so no clearing pass is needed;
// config returns to 1024 x 1024 world with cells 64 units wide.
module uniform_grid_spatial_index (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_req_type,
    input  logic [31:0]        i_entity_id,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_radius,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_found_id,
    output logic               o_hit,
    output logic               o_last,
    output logic [1:0]         o_status,
    output logic [6:0]         o_entity_count,
    // config write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import ugsi_pkg::*;

    t_geom            r_geom;
    t_emit            emit;
    logic             emit_ok;
    logic             ready;
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_quot;

    logic             r_out_valid;
    logic [31:0]      r_found_id;
    logic             r_hit;
    logic             r_last;
    logic [1:0]       r_status;
    logic [6:0]       r_count;

    // config registers, to be written only while no request is in flight
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.extent_x <= 16'd1024;
            r_geom.extent_y <= 16'd1024;
            r_geom.cell_len <= 16'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WORLD_W:   r_geom.extent_x <= i_cfg_data;
                CFG_WORLD_H:   r_geom.extent_y <= i_cfg_data;
                CFG_CELL_SIZE: r_geom.cell_len <= i_cfg_data;
                default:       r_geom <= r_geom;
            endcase
        end
    end

    ugsi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    ugsi_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_ready        (ready),
        .i_req_type     (i_req_type),
        .i_entity_id    (i_entity_id),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_radius       (i_radius),
        .i_geom         (r_geom),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quot     (div_quot),
        .o_emit         (emit),
        .i_emit_ok      (emit_ok)
    );

    assign o_in_stall = !ready;

    // result register: loads when empty or being taken this cycle
    assign emit_ok = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid && emit_ok) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid && emit_ok) begin
            r_found_id <= emit.id;
            r_hit      <= emit.hit;
            r_last     <= emit.last;
            r_status   <= emit.status;
            r_count    <= emit.count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found_id     = r_found_id;
    assign o_hit          = r_hit;
    assign o_last         = r_last;
    assign o_status       = r_status;
    assign o_entity_count = r_count;

endmodule

// ----- rtl/ugsi_checker.sv -----
// port-level checker for the uniform grid spatial index, bound to the top level
// depends on ugsi_pkg and uniform_grid_spatial_index_defines.svh
`include "uniform_grid_spatial_index_defines.svh"

module ugsi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_found_id,
    input logic        o_hit,
    input logic        o_last,
    input logic [1:0]  o_status,
    input logic [6:0]  o_entity_count
);
    import ugsi_pkg::*;

    // a stalled result stays put
    `UGSI_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_found_id) && $stable(o_hit) && $stable(o_last), "stalled result changed")

    // a result without a hit always closes its request and carries no id
    `UGSI_ASSERT_NOW(a_miss_last, o_out_valid && !o_hit, o_last && o_found_id == '0, "miss result not last or has id")

    // query hits never report a failure status
    `UGSI_ASSERT_NOW(a_hit_done, o_out_valid && o_hit, o_status == ST_DONE, "hit with non-done status")

    // count never exceeds capacity
    `UGSI_ASSERT_NOW(a_count_cap, o_out_valid, o_entity_count <= CNT_W'(MAX_ENTITIES), "entity count over capacity")

endmodule

bind uniform_grid_spatial_index ugsi_checker u_ugsi_checker (.*);
